// ----- src/gmn_pkg.sv -----
// gmn_pkg: shared types and constants for the gray min-max normalizer
// no dependencies
package gmn_pkg;
  localparam int FRAME_PIXELS = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W = $clog2(FRAME_PIXELS);
  localparam int CNT_W = ADDR_W + 1;
  localparam int V_W = 24;
  localparam int NUM_W = V_W + 8;
  localparam logic [16:0] COEF_R = 17'd19589;
  localparam logic [16:0] COEF_G = 17'd38470;
  localparam logic [16:0] COEF_B = 17'd7471;
  localparam logic [2:0] SPP_GRAY = 3'd1;
  localparam logic [2:0] SPP_RGB = 3'd3;
  localparam logic ACT_LOAD = 1'b0;

  typedef struct packed {
    logic        action;
    logic [15:0] red_or_gray;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] scaled_value;
    logic       last_out;
    logic       format_error;
  } out_item_t;

  // job handed to the divider
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [V_W-1:0]   den;
    logic             flat;
    logic             last;
    logic             err;
  } div_job_t;
endpackage

// ----- src/gmn_ram.sv -----
// gmn_ram: pixel store, one write port and one registered read port
// depends on gmn_pkg
module gmn_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [gmn_pkg::ADDR_W-1:0] waddr,
  input  logic [gmn_pkg::V_W-1:0]    wdata,
  input  logic                      re,
  input  logic [gmn_pkg::ADDR_W-1:0] raddr,
  output logic [gmn_pkg::V_W-1:0]    rdata
);
  logic [gmn_pkg::V_W-1:0] mem [gmn_pkg::FRAME_PIXELS];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- src/gmn_div.sv -----
// gmn_div: restoring divider, ceil(num/den) clamped to 255 (0 if flat), one bit per cycle
// depends on gmn_pkg
module gmn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gmn_pkg::div_job_t   job,
  output logic                busy,
  output logic                done,
  output gmn_pkg::out_item_t  result
);
  localparam int N = gmn_pkg::NUM_W;
  localparam int SW = $clog2(N + 1);

  logic [N-1:0] quo_r, quo_nxt;
  logic [gmn_pkg::V_W:0] rem_r, rem_nxt;
  logic [gmn_pkg::V_W-1:0] den_r;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic flat_r, last_r, err_r;
  logic [gmn_pkg::V_W:0] trial;
  logic [N-1:0] qfin;

  // one quotient bit per cycle
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      quo_nxt = job.num;
      rem_nxt = '0;
      cnt_nxt = SW'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[gmn_pkg::V_W-1:0], quo_r[N-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= job.den;
      flat_r <= job.flat;
      last_r <= job.last;
      err_r <= job.err;
    end
  end

  // round up on nonzero remainder, clamp
  always_comb begin
    qfin = quo_r + N'(rem_r != '0);
    result.scaled_value = flat_r ? 8'd0 :
                          (qfin > N'(255) ? 8'd255 : qfin[7:0]);
    result.last_out = last_r;
    result.format_error = err_r;
  end

  assign busy = busy_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("start did not raise busy");
`endif
endmodule

// ----- src/gray_minmax_normalize_top.sv -----
// gray_minmax_normalize_top: gray frame loader with min-max stretch readout
// depends on gmn_pkg, gmn_ram, gmn_div
//
// usage:
//   in_* channel (valid/stall) carries load or readout-request transactions.
//   a load (action 0) converts one pixel to Q16.8 gray, stores it and updates
//   running min/max; last_pixel closes the frame. a load after a closed frame
//   starts a new one.
//   a request (action 1) on a closed, nonempty frame yields one out_*
//   transaction: ceil((v-min)*255/(max-min)), 0 on a flat frame, in load
//   order, wrapping after the final pixel. other requests yield nothing.
//   cfg_* (valid/ready) writes samples_per_pixel; ready is always high.
// sequencing:
//   a load registers the gray value at acceptance, then writes it to the store;
//   the input stalls during the write, so a new load waits for it to finish.
//   a request result passes through: store read at acceptance, numerator
//   multiply, divider load, the divider's quotient steps, one result register.
//   the input stalls while the divider works and while a result waits in the
//   output register, so a new request is taken only after the last result is taken.
// reset: synchronous active low; control state cleared, store not cleared.
// stall on out_* holds the result and keeps in_* stalled until it is taken.
module gray_minmax_normalize_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gmn_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gmn_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_data
);
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_STORE = 5'b00010,
    ST_READ  = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] spp_r;
  logic [gmn_pkg::CNT_W-1:0] count_r, rptr_r;
  logic [gmn_pkg::V_W-1:0] min_r, max_r, gray_r, rd_v;
  logic err_r, loaded_r, bad_r, lastp_r;
  logic [33:0] acc;
  logic [gmn_pkg::V_W-1:0] gray_c;
  logic in_acc, out_acc;
  logic ram_we, ram_re;
  logic [gmn_pkg::ADDR_W-1:0] raddr;
  logic [gmn_pkg::CNT_W-1:0] rp_eff;
  logic req_last_r;
  logic [gmn_pkg::NUM_W-1:0] num_r;
  gmn_pkg::div_job_t job;
  logic div_start, div_busy, div_done;
  gmn_pkg::out_item_t div_res, out_r;
  logic out_valid_r;
  logic [15:0] sr, sg, sb;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) spp_r <= gmn_pkg::SPP_GRAY;
    else if (cfg_valid && cfg_ready) spp_r <= cfg_data;
  end

  // gray conversion
  always_comb begin
    sr = in_data.red_or_gray & 16'((1 << gmn_pkg::SAMPLE_BITS) - 1);
    sg = in_data.green & 16'((1 << gmn_pkg::SAMPLE_BITS) - 1);
    sb = in_data.blue & 16'((1 << gmn_pkg::SAMPLE_BITS) - 1);
    acc = 34'(gmn_pkg::COEF_R) * 34'(sr) + 34'(gmn_pkg::COEF_G) * 34'(sg)
        + 34'(gmn_pkg::COEF_B) * 34'(sb) + 34'd128;
    case (spp_r)
      gmn_pkg::SPP_GRAY: gray_c = {sr, 8'd0};
      gmn_pkg::SPP_RGB:  gray_c = acc[31:8];
      default:           gray_c = '0;
    endcase
  end

  // read pointer wrap
  assign rp_eff = (rptr_r >= count_r) ? '0 : rptr_r;
  assign raddr = rp_eff[gmn_pkg::ADDR_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ram_re = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.action == gmn_pkg::ACT_LOAD) begin
          state_nxt = ST_STORE;
        end else if (in_acc && loaded_r && count_r != '0) begin
          ram_re = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_STORE: state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ram_we = (state_r == ST_STORE) && (count_r < gmn_pkg::CNT_W'(gmn_pkg::FRAME_PIXELS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rptr_r <= '0;
      min_r <= '1;
      max_r <= '0;
      err_r <= 1'b0;
      loaded_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_acc && in_data.action == gmn_pkg::ACT_LOAD
          && loaded_r) begin
        count_r <= '0;
        rptr_r <= '0;
        min_r <= '1;
        max_r <= '0;
        err_r <= 1'b0;
        loaded_r <= 1'b0;
      end
      if (state_r == ST_STORE) begin
        if (ram_we) begin
          count_r <= count_r + 1'b1;
          if (gray_r < min_r) min_r <= gray_r;
          if (gray_r > max_r) max_r <= gray_r;
          if (bad_r) err_r <= 1'b1;
        end
        if (lastp_r) loaded_r <= 1'b1;
      end
      if (ram_re) rptr_r <= rp_eff + 1'b1;
      if (div_done) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      gray_r <= gray_c;
      bad_r <= (spp_r != gmn_pkg::SPP_GRAY) && (spp_r != gmn_pkg::SPP_RGB);
      lastp_r <= in_data.last_pixel;
    end
    if (ram_re) req_last_r <= (rp_eff + 1'b1) == count_r;
    if (state_r == ST_READ)
      num_r <= (rd_v >= min_r) ? gmn_pkg::NUM_W'(rd_v - min_r) * 8'd255 : '0;
    if (div_done) out_r <= div_res;
  end

  assign job.num = num_r;
  assign job.den = max_r - min_r;
  assign job.flat = max_r <= min_r;
  assign job.last = req_last_r;
  assign job.err = err_r;

  gmn_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(count_r[gmn_pkg::ADDR_W-1:0]),
    .wdata(gray_r), .re(ram_re), .raddr(raddr), .rdata(rd_v)
  );

  gmn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .job(job),
    .busy(div_busy), .done(div_done), .result(div_res)
  );

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == ST_DIV) else $error("divider busy outside div state");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gmn_pkg::CNT_W'(gmn_pkg::FRAME_PIXELS)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r) else $error("result dropped");
`endif
endmodule
